FILE: design/sec2cal_pkg.sv
// ============================================================================
// sec2cal_pkg: shared types and constants for seconds_to_calendar_date
// Holds the divider select codes, the controller/datapath command and status
// structs, the time constants and the month length table.
// ============================================================================
`default_nettype none

package sec2cal_pkg;

    localparam int SecsW   = 32;
    localparam int DivisorW = 17;
    localparam int DaysW   = 16;
    localparam int YearW   = 12;
    localparam int YearCntW = 13;

    localparam logic [DivisorW-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [DivisorW-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [DivisorW-1:0] SECS_PER_MIN  = 17'd60;

    // reciprocals for the division passes, applied after dropping the
    // power-of-two factor of each divisor
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675)
    localparam logic [13:0] HOUR_RECIP = 14'd9321;      // ceil(2^21 / 225)
    localparam logic [10:0] MIN_RECIP  = 11'd1093;      // ceil(2^14 / 15)

    // each division pass: quotient step, then remainder step
    localparam logic DIV_STEP_LAST = 1'b1;

    localparam logic [YearW-1:0] BASE_YEAR_RESET = 12'd1970;

    localparam logic [YearW-1:0] LEAP_CYCLE      = 12'd400;
    localparam logic [YearW-1:0] LEAP_CYCLE_X4   = 12'd1600;
    localparam logic [YearW-1:0] LEAP_CYCLE_LAST = 12'd399;
    localparam logic [YearW-1:0] CENTURY_1       = 12'd100;
    localparam logic [YearW-1:0] CENTURY_2       = 12'd200;
    localparam logic [YearW-1:0] CENTURY_3       = 12'd300;

    localparam logic [8:0] YEAR_LEN_COMMON = 9'd365;
    localparam logic [8:0] YEAR_LEN_LEAP   = 9'd366;

    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd11;
    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

    typedef enum logic [1:0] {
        DIV_DAY  = 2'd0,
        DIV_HOUR = 2'd1,
        DIV_MIN  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     div_step;
        logic     div_last;
        div_sel_t div_sel;
        logic     year_step;
        logic     month_step;
        logic     month_end;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
        logic month_last;
        logic out_busy;
    } status_t;

    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: design/sec2cal_dp.sv
// ============================================================================
// sec2cal_dp: conversion datapath
// Reciprocal-multiply divider, leap-aware year and month reduction, base year
// register and the output register.
// ============================================================================
`default_nettype none

module sec2cal_dp
    import sec2cal_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output status_t                  status,
    input  wire logic [SecsW-1:0]    elapsed_seconds,
    input  wire logic                cfg_valid,
    input  wire logic [YearW-1:0]    cfg_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [39:0]              m_tdata
);

    logic [YearW-1:0]    base_year_reg;
    logic                out_valid_reg;
    logic [39:0]         out_reg;

    logic [SecsW-1:0]    dvd_reg;
    logic [DaysW-1:0]    quo_reg;
    logic [DaysW-1:0]    days_reg;
    logic [YearCntW-1:0] year_reg;
    logic [YearW-1:0]    y400_reg;
    logic [3:0]          mon_reg;
    logic [4:0]          hour_reg;
    logic [5:0]          minute_reg;
    logic [5:0]          second_reg;
    logic [3:0]          month_out_reg;

    logic [DivisorW-1:0] divisor;
    logic [50:0]         day_prod;
    logic [26:0]         hour_prod;
    logic [20:0]         min_prod;
    logic [DaysW-1:0]    q_calc;
    logic [32:0]         back_prod;
    logic [DivisorW-1:0] rem_calc;
    logic                century;
    logic                leap;
    logic [8:0]          ylen;
    logic [4:0]          mlen;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_DAY:  divisor = SECS_PER_DAY;
            DIV_HOUR: divisor = SECS_PER_HOUR;
            DIV_MIN:  divisor = SECS_PER_MIN;
            default:  divisor = SECS_PER_DAY;
        endcase
    end

    // quotient by reciprocal: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
    assign day_prod  = dvd_reg[SecsW-1:7] * DAY_RECIP;
    assign hour_prod = dvd_reg[16:4] * HOUR_RECIP;
    assign min_prod  = dvd_reg[11:2] * MIN_RECIP;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_DAY:  q_calc = day_prod[50:35];
            DIV_HOUR: q_calc = {10'b0, hour_prod[26:21]};
            DIV_MIN:  q_calc = {9'b0, min_prod[20:14]};
            default:  q_calc = day_prod[50:35];
        endcase
    end

    // remainder fits in 17 bits, so the low bits of the difference are exact
    assign back_prod = quo_reg * divisor;
    assign rem_calc  = dvd_reg[DivisorW-1:0] - back_prod[DivisorW-1:0];

    // leap rule on the running year; y400_reg is year mod 400 once reduced
    assign century = (y400_reg == '0) || (y400_reg == CENTURY_1) ||
                     (y400_reg == CENTURY_2) || (y400_reg == CENTURY_3);
    assign leap    = (y400_reg == '0) || ((year_reg[1:0] == 2'b00) && !century);
    assign ylen    = leap ? YEAR_LEN_LEAP : YEAR_LEN_COMMON;
    assign mlen    = ((mon_reg == MONTH_FEB) && leap) ? FEB_LEAP_LEN : month_len(mon_reg);

    assign status.year_fit   = (days_reg <= {{(DaysW-9){1'b0}}, ylen});
    assign status.month_fit  = (days_reg <= {{(DaysW-5){1'b0}}, mlen});
    assign status.month_last = (mon_reg == MONTH_DEC);
    assign status.out_busy   = out_valid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_year_reg <= BASE_YEAR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                base_year_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            dvd_reg  <= elapsed_seconds;
            year_reg <= {1'b0, base_year_reg};
            y400_reg <= base_year_reg;
            mon_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            // reduce the year mod 400 in the background; at most four steps
            if (y400_reg >= LEAP_CYCLE_X4)
            begin
                y400_reg <= y400_reg - LEAP_CYCLE_X4;
            end
            else if (y400_reg >= LEAP_CYCLE)
            begin
                y400_reg <= y400_reg - LEAP_CYCLE;
            end
            if (cmd.div_last)
            begin
                case (cmd.div_sel)
                    DIV_DAY:
                    begin
                        days_reg <= quo_reg + {{(DaysW-1){1'b0}}, 1'b1};
                        dvd_reg  <= {{(SecsW-DivisorW){1'b0}}, rem_calc};
                    end
                    DIV_HOUR:
                    begin
                        hour_reg <= quo_reg[4:0];
                        dvd_reg  <= {{(SecsW-12){1'b0}}, rem_calc[11:0]};
                    end
                    DIV_MIN:
                    begin
                        minute_reg <= quo_reg[5:0];
                        second_reg <= rem_calc[5:0];
                    end
                    default:
                    begin
                        days_reg <= days_reg;
                    end
                endcase
            end
            else
            begin
                quo_reg <= q_calc;
            end
        end
        if (cmd.year_step)
        begin
            days_reg <= days_reg - {{(DaysW-9){1'b0}}, ylen};
            year_reg <= year_reg + {{(YearCntW-1){1'b0}}, 1'b1};
            y400_reg <= (y400_reg == LEAP_CYCLE_LAST) ? '0
                                                      : y400_reg + {{(YearW-1){1'b0}}, 1'b1};
        end
        if (cmd.month_step)
        begin
            days_reg <= days_reg - {{(DaysW-5){1'b0}}, mlen};
            mon_reg  <= mon_reg + 4'd1;
        end
        if (cmd.month_end)
        begin
            month_out_reg <= mon_reg + 4'd1;
            if (!status.month_fit)
            begin
                days_reg <= days_reg - {{(DaysW-5){1'b0}}, mlen};
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= {2'b00, second_reg, minute_reg, hour_reg, days_reg[4:0],
                        month_out_reg, year_reg[YearW-1:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTH
    a_year_step_needs_excess: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.year_step |-> !status.year_fit)
        else $error("year subtracted while the day count fits in it");

    a_result_month_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid && (m_tdata[15:12] != 4'd0) && (m_tdata[15:12] <= 4'd12))
        else $error("result month out of range");
`endif

endmodule

`default_nettype wire

FILE: design/sec2cal_ctrl.sv
// ============================================================================
// sec2cal_ctrl: conversion sequencer
// One-hot state machine stepping the divider passes, the year and month
// reduction and the result hand-off.
// ============================================================================
`default_nettype none

module sec2cal_ctrl
    import sec2cal_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DAY   = 7'b0000010,
        S_HOUR  = 7'b0000100,
        S_MIN   = 7'b0001000,
        S_YEAR  = 7'b0010000,
        S_MONTH = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic       cnt_reg;
    logic       cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.div_sel = DIV_DAY;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_DAY;
                end
            end
            S_DAY:
            begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_DAY;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_STEP_LAST)
                begin
                    cmd.div_last = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_HOUR;
                end
            end
            S_HOUR:
            begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_HOUR;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_STEP_LAST)
                begin
                    cmd.div_last = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_MIN;
                end
            end
            S_MIN:
            begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_MIN;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_STEP_LAST)
                begin
                    cmd.div_last = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (status.year_fit)
                begin
                    state_next = S_MONTH;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            S_MONTH:
            begin
                if (status.month_fit || status.month_last)
                begin
                    cmd.month_end = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.month_step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTH
    a_accept_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_DAY) && (cnt_reg == 1'b0))
        else $error("accepted request did not start the day division");

    a_day_pass_length: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DAY) && (cnt_reg == DIV_STEP_LAST)) |=>
            (state_reg == S_HOUR) && (cnt_reg == 1'b0))
        else $error("day division did not hand over to the hour division");
`endif

endmodule

`default_nettype wire

FILE: design/seconds_to_calendar_date.sv
// ============================================================================
// seconds_to_calendar_date: epoch seconds to Gregorian date and time
// Converts a 32-bit seconds count since January 1 of a programmable base
// year into year, month, day, hour, minute and second.
// ============================================================================
//
// One request is converted at a time. After acceptance, three division
// passes (quotient by reciprocal multiply, then remainder) split the
// count by 86400, 3600 and 60; then whole years are subtracted one per
// cycle under the full Gregorian leap rule, then months one per cycle
// with a 29-day February in leap years. Up to 136 whole years are stepped.
// The hand-off holds while a previous result still waits on m_tready.
// The result sits in an output register, so the next request is accepted
// while the previous result waits on m_tready. The base year register
// resets to 1970 and should be written only while the block is idle;
// cfg_ready is always high. The year field carries the low 12 bits of the
// year, while leap decisions use the full year.
`default_nettype none

module seconds_to_calendar_date
    import sec2cal_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] elapsed_seconds
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [11:0] year, [15:12] month, [20:16] day,
                                        // [25:21] hour, [31:26] minute,
                                        // [37:32] second, [39:38] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data   // [11:0] base_year
);

    cmd_t    cmd;
    status_t status;

    // configuration is taken in any cycle
    assign cfg_ready = 1'b1;

    sec2cal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sec2cal_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .elapsed_seconds (s_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

endmodule

`default_nettype wire

FILE: bench/seconds_to_calendar_date_tb.sv
// ============================================================================
// seconds_to_calendar_date_tb: self-checking bench for the calendar converter
// Drives seconds counts into the stream input under random gaps and output
// stalls, and reprograms the base year between phases. A scoreboard class
// works out the expected calendar date of every accepted request and
// compares it field by field with each result leaving the block.
// ============================================================================

module seconds_to_calendar_date_tb;
    import sec2cal_pkg::*;

    // Cycle limit: the slowest request plus the worst input gap and output
    // stall, times roughly 2000 requests, then a wide margin.
    localparam int CycleLimit = 2_000_000;
    // Longest conversion plus headroom, used for the final quiet period.
    localparam int DrainCycles = 300;
    localparam int RandomPhases = 8;
    localparam int RequestsPerPhase = 240;

    // Result word as it sits on m_tdata: year in the low bits.
    typedef struct packed {
        logic [1:0]  pad;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } cal_date_t;

    typedef struct {
        logic [31:0] secs;
        logic [11:0] base;
        cal_date_t   date;
    } pending_date_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds the base year the block should be using and a FIFO
    // of the dates it owes us, oldest first.
    // ------------------------------------------------------------------------
    class calendar_scoreboard;
        logic [11:0]   base_year;
        pending_date_t pending_dates[$];
        int            errors;
        int unsigned   month_table[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

        function new();
            base_year = BASE_YEAR_RESET;
            errors = 0;
        endfunction

        function bit is_leap(int unsigned y);
            return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        endfunction

        function int unsigned year_days(int unsigned y);
            return is_leap(y) ? 366 : 365;
        endfunction

        function int unsigned month_days(int unsigned y, int m);
            return (m == 1 && is_leap(y)) ? 29 : month_table[m];
        endfunction

        // Walk whole years, then months, from the configured base year.
        // The year counter runs unbounded; only the output is cut to 12 bits.
        function cal_date_t to_calendar(logic [31:0] secs);
            int unsigned day_num;
            int unsigned rem;
            int unsigned yr;
            int unsigned ylen;
            int unsigned mlen;
            cal_date_t   d;
            day_num = secs / SECS_PER_DAY + 1;
            rem = secs % SECS_PER_DAY;
            yr = base_year;
            ylen = year_days(yr);
            while (day_num > ylen)
            begin
                day_num -= ylen;
                yr++;
                ylen = year_days(yr);
            end
            d = '0;
            d.month = 4'd12;
            for (int m = 0; m < 12; m++)
            begin
                mlen = month_days(yr, m);
                if (day_num <= mlen)
                begin
                    d.month = 4'(m + 1);
                    break;
                end
                day_num -= mlen;
            end
            d.year = yr[11:0];
            d.day = day_num[4:0];
            d.hour = 5'(rem / SECS_PER_HOUR);
            d.minute = 6'((rem % SECS_PER_HOUR) / SECS_PER_MIN);
            d.second = 6'(rem % SECS_PER_MIN);
            return d;
        endfunction

        function int pending();
            return pending_dates.size();
        endfunction

        function void note_request(logic [31:0] secs);
            pending_date_t p;
            p.secs = secs;
            p.base = base_year;
            p.date = to_calendar(secs);
            pending_dates.push_back(p);
        endfunction

        // Print one line per failure and count it.
        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task compare_field(string name, logic [11:0] got, logic [11:0] want,
                           pending_date_t p);
            if (got !== want)
                report($sformatf("%s: secs=%0d base=%0d got %0d want %0d",
                                 name, p.secs, p.base, got, want));
        endtask

        task check_result(cal_date_t got);
            pending_date_t p;
            if (pending_dates.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            p = pending_dates.pop_front();
            compare_field("year", got.year, p.date.year, p);
            compare_field("month", 12'(got.month), 12'(p.date.month), p);
            compare_field("day", 12'(got.day), 12'(p.date.day), p);
            compare_field("hour", 12'(got.hour), 12'(p.date.hour), p);
            compare_field("minute", 12'(got.minute), 12'(p.date.minute), p);
            compare_field("second", 12'(got.second), 12'(p.date.second), p);
            compare_field("pad", 12'(got.pad), 12'(p.date.pad), p);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] elapsed_seconds
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
                            // [31:26] minute, [37:32] second, [39:38] zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;  // [11:0] base_year

    calendar_scoreboard sb = new();
    bit steady = 1'b0;      // when set, neither side idles
    int cycles = 0;

    seconds_to_calendar_date DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake must not stall the run forever.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("seconds_to_calendar_date_tb: done, errors");
            $finish;
        end
    end

    // Check every result at the edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(cal_date_t'(m_tdata));
    end

    function int draw_wait();
        return steady ? 0 : int'($urandom_range(0, 6));
    endfunction

    // Receiver: stall a random number of cycles before taking each result.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Present one request after a random gap and hold it until taken.
    // Valid only drops when a gap follows, so back-to-back requests keep it high.
    task send_request(logic [31:0] secs);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= secs;
        do @(posedge clk); while (!s_tready);
        sb.note_request(secs);
    endtask

    // Drop the input and hold off until every owed result has come back.
    task wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task write_base_year(logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.base_year = value;
    endtask

    // Seconds count aimed at a year or month boundary a random number of
    // years past the base: its first second, the one before it, or a random second of that day.
    function logic [31:0] boundary_secs();
        longint      days;
        longint      total;
        int unsigned yr;
        int          months;
        days = 0;
        yr = sb.base_year;
        repeat ($urandom_range(0, 136))
        begin
            days += sb.year_days(yr);
            yr++;
        end
        months = $urandom_range(0, 11);
        for (int m = 0; m < months; m++)
            days += sb.month_days(yr, m);
        total = days * 86400;
        case ($urandom_range(0, 2))
            0: total -= 1;
            1: total += $urandom_range(0, 86399);
            default: ;
        endcase
        if (total < 0 || total > 64'hFFFF_FFFF)
            return $urandom();
        return total[31:0];
    endfunction

    function logic [31:0] random_secs();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return boundary_secs();
            7:          return $urandom_range(0, 3 * 86400);
            8:          return 32'hFFFF_FFFF - $urandom_range(0, 400 * 86400);
            default:    return 32'($urandom_range(0, 49709) * 86400
                                   + ($urandom_range(0, 1) ? 86399 : 0));
        endcase
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset base year: time-of-day extremes, first year end, leap Febs
        // in 1972 and 2000, the skipped leap day of 2100, and the top count.
        send_request(32'd0);
        send_request(32'd1);
        send_request(32'd59);
        send_request(32'd60);
        send_request(32'd3599);
        send_request(32'd3600);
        send_request(32'd86399);
        send_request(32'd86400);
        send_request(32'(365 * 86400 - 1));
        send_request(32'(365 * 86400));
        send_request(32'((730 + 59) * 86400));
        send_request(32'((730 + 60) * 86400));
        send_request(32'((10957 + 59) * 86400));
        send_request(32'(64'(47482 + 59) * 86400));
        send_request(32'hFFFF_FFFF);
        send_request(32'hAAAA_AAAA);
        send_request(32'h5555_5555);
        wait_idle();

        // Top 12-bit base year: the year count wraps past 4095.
        write_base_year(12'd4095);
        send_request(32'hFFFF_FFFF);
        send_request(32'(365 * 86400));
        wait_idle();

        // Year zero is a leap year.
        write_base_year(12'd0);
        send_request(32'(59 * 86400));
        send_request(32'(365 * 86400));
        wait_idle();

        // Ends of the usual range: 1900 has no leap day, 2400 does.
        write_base_year(12'd1900);
        send_request(32'(59 * 86400));
        wait_idle();
        write_base_year(12'd2400);
        send_request(32'(59 * 86400));
        wait_idle();

        // Random phases, each with its own base year; every third runs with
        // no idling on either side. Now and then drain mid-phase.
        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            if ($urandom_range(0, 3) == 0)
                write_base_year(12'($urandom_range(0, 4095)));
            else
                write_base_year(12'($urandom_range(1900, 2400)));
            steady = (phase % 3 == 1);
            for (int i = 0; i < RequestsPerPhase; i++)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
                send_request(random_secs());
            end
            wait_idle();
        end

        // Quiet period: anything arriving now is a stray result.
        repeat (DrainCycles) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("seconds_to_calendar_date_tb: done, clean");
        else
            $display("seconds_to_calendar_date_tb: done, errors");
        $finish;
    end

endmodule
